@@ rtl/core/ptab_pkg.sv @@
// Shared types and constants of the pixel tint and blend pipeline.
package ptab_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TINT_RED      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TINT_GREEN    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TINT_BLUE     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BACK_RED      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BACK_GREEN    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BACK_BLUE     = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DISABLED_LOOK = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTPUT_MODE   = 3'd7;

   // Output modes; the unused code behaves as opaque
   localparam logic [1:0] MODE_OPAQUE = 2'd0;
   localparam logic [1:0] MODE_ALPHA  = 2'd1;
   localparam logic [1:0] MODE_BLEND  = 2'd2;

   // Colour channel lanes
   localparam int unsigned LANE_RED   = 0;
   localparam int unsigned LANE_GREEN = 1;
   localparam int unsigned LANE_BLUE  = 2;
   localparam int unsigned NUM_LANES  = 3;

   typedef logic [NUM_LANES-1:0][7:0] rgb8_type;

   typedef struct packed {
      logic [7:0] scale_value;
      logic [7:0] add_value;
      logic [7:0] alpha_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_type;

   // Per-stage load enables, first stage to last
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

endpackage

@@ rtl/core/pixel_tint_and_blend.sv @@
// Top level of the pixel tint and blend pipeline: registers, flow control, stages.
//
// Usage:
//   req_* carries one template pixel (scale, add and alpha bytes) per transaction
//   under valid/ready; rsp_* returns one RGBA pixel per transaction, in order.
//   csr_* is a plain write port: index 0..7 picks tint red/green/blue,
//   background red/green/blue, the disabled look and the output mode.
//   Write configuration only while no transaction is in flight.
// Latency and throughput:
//   Five register stages: an accepted pixel lands in the first stage at the
//   edge that takes it and moves through the stages in order to rsp_*. One
//   pixel per clock is sustained, as every stage takes a new pixel each cycle
//   while the receiver keeps up; the five stages, cut around the multipliers in
//   stages two and four, set the latency.
// Reset:
//   Synchronous reset empties the pipeline and clears the configuration registers
//   to zero (normal look, opaque output, black tint and background).
// Receiver stall:
//   Each stage holds while the stage after it is full and stalled; a bubble
//   in front of the stall still fills, so req_ready only drops once all five
//   stages hold pixels and rsp_ready is low. Nothing is dropped or repeated.
module pixel_tint_and_blend (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  ptab_pkg::req_type                       req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output ptab_pkg::rsp_type                       rsp_data,
   input  logic                                    csr_write_en,
   input  logic [ptab_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [ptab_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data
);

   localparam int unsigned NUM_STAGES = 5;

   // Configuration registers
   ptab_pkg::rgb8_type tint_ff, back_ff;
   logic               disabled_look_ff;
   logic [1:0]         output_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tint_ff          <= '0;
         back_ff          <= '0;
         disabled_look_ff <= 1'b0;
         output_mode_ff   <= ptab_pkg::MODE_OPAQUE;
      end else if (csr_write_en) begin
         case (csr_index)
            ptab_pkg::CSR_TINT_RED:      tint_ff[ptab_pkg::LANE_RED]   <= csr_write_data;
            ptab_pkg::CSR_TINT_GREEN:    tint_ff[ptab_pkg::LANE_GREEN] <= csr_write_data;
            ptab_pkg::CSR_TINT_BLUE:     tint_ff[ptab_pkg::LANE_BLUE]  <= csr_write_data;
            ptab_pkg::CSR_BACK_RED:      back_ff[ptab_pkg::LANE_RED]   <= csr_write_data;
            ptab_pkg::CSR_BACK_GREEN:    back_ff[ptab_pkg::LANE_GREEN] <= csr_write_data;
            ptab_pkg::CSR_BACK_BLUE:     back_ff[ptab_pkg::LANE_BLUE]  <= csr_write_data;
            ptab_pkg::CSR_DISABLED_LOOK: disabled_look_ff <= csr_write_data[0];
            ptab_pkg::CSR_OUTPUT_MODE:   output_mode_ff   <= csr_write_data[1:0];
            default: begin
               // every index names a register; nothing else to hold
            end
         endcase
      end
   end

   // Stage valid bits; bit 0 is the first stage, the last one drives rsp_valid.
   // A stage advances when it is empty or the stage after it advances.
   logic [NUM_STAGES-1:0] valid_in, valid_ff, adv;
   ptab_pkg::stage_en_type stage_en;
   logic req_fire, rsp_fire;

   always_comb begin
      adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      valid_in[0] = adv[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign stage_en.s1 = adv[0];
   assign stage_en.s2 = adv[1];
   assign stage_en.s3 = adv[2];
   assign stage_en.s4 = adv[3];
   assign stage_en.s5 = adv[4];

   assign req_ready = adv[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // Datapath: tint in stages one to three, blend in stages four and five
   ptab_pkg::rgb8_type chan;
   logic [7:0]         chan_alpha;

   ptab_tint u_tint (
      .clock         (clock),
      .tint          (tint_ff),
      .disabled_look (disabled_look_ff),
      .stage_en      (stage_en),
      .req_data      (req_data),
      .chan          (chan),
      .alpha         (chan_alpha)
   );

   ptab_blend u_blend (
      .clock       (clock),
      .chan        (chan),
      .alpha       (chan_alpha),
      .back        (back_ff),
      .output_mode (output_mode_ff),
      .stage_en    (stage_en),
      .rsp_data    (rsp_data)
   );

   // Accepted transaction lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> valid_ff[0])
      else $error("accepted transaction missing from first stage");

   // Input stalls only with a full pipeline and a stalled receiver
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> ((&valid_ff) && !rsp_ready))
      else $error("input stalled with room in the pipeline");

   // Occupancy tracks transactions in and out exactly
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ($countones(valid_ff) ==
         $countones($past(valid_ff)) + int'($past(req_fire)) - int'($past(rsp_fire))))
      else $error("transaction lost or duplicated in pipeline");

   // Alpha is opaque unless passed through
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (output_mode_ff != ptab_pkg::MODE_ALPHA)) |-> (rsp_data.out_alpha == 8'hFF))
      else $error("non-opaque alpha outside pass-through mode");

endmodule

@@ rtl/core/ptab_tint.sv @@
// Tint stages: tint and gray preparation, scale products, add and saturate.
module ptab_tint (
   input  logic                    clock,
   input  ptab_pkg::rgb8_type      tint,
   input  logic                    disabled_look,
   input  ptab_pkg::stage_en_type  stage_en,
   input  ptab_pkg::req_type       req_data,
   output ptab_pkg::rgb8_type      chan,
   output logic [7:0]              alpha
);

   // Stage 1: tint channels, gray, add*5/4
   logic [ptab_pkg::NUM_LANES-1:0][8:0] t_in, t_ff;
   logic [12:0] gray_wide;
   logic [7:0]  gray_in, gray_ff;
   logic [8:0]  add5_in, add5_ff;
   logic [7:0]  scale1_ff, add1_ff, alpha1_ff;
   logic [ptab_pkg::NUM_LANES-1:0][9:0] mix;

   always_comb begin
      gray_wide = 13'(tint[ptab_pkg::LANE_RED]) * 13'd11
                + 13'({tint[ptab_pkg::LANE_GREEN], 4'b0000})
                + 13'(tint[ptab_pkg::LANE_BLUE]) * 13'd5;
      gray_in   = gray_wide[12:5];
      add5_in   = {1'b0, req_data.add_value} + 9'(req_data.add_value[7:2]);
      for (int i = 0; i < ptab_pkg::NUM_LANES; i++) begin
         mix[i] = {2'b00, tint[i]} + {1'b0, tint[i], 1'b0} + {2'b00, gray_in};
         t_in[i] = disabled_look ? {1'b0, mix[i][9:2]} : ({1'b0, tint[i]} + 9'd2);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         t_ff      <= t_in;
         gray_ff   <= gray_in;
         add5_ff   <= add5_in;
         scale1_ff <= req_data.scale_value;
         add1_ff   <= req_data.add_value;
         alpha1_ff <= req_data.alpha_value;
      end
   end

   // Stage 2: scale products and gray-weighted add
   logic [ptab_pkg::NUM_LANES-1:0][16:0] pt_in, pt_ff;
   logic [15:0] pa_in, pa_ff;
   logic [8:0]  addn_in, addn_ff;
   logic [7:0]  alpha2_ff;

   always_comb begin
      for (int i = 0; i < ptab_pkg::NUM_LANES; i++) begin
         pt_in[i] = 17'(t_ff[i]) * 17'(scale1_ff);
      end
      pa_in   = 16'(add1_ff) * 16'(gray_ff);
      addn_in = (scale1_ff != 8'd0) ? add5_ff : {1'b0, add1_ff};
   end

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         pt_ff     <= pt_in;
         pa_ff     <= pa_in;
         addn_ff   <= addn_in;
         alpha2_ff <= alpha1_ff;
      end
   end

   // Stage 3: round, add and saturate each channel
   logic [16:0] pa_rnd;
   logic [8:0]  add_sel;
   logic [ptab_pkg::NUM_LANES-1:0][17:0] pt_rnd;
   logic [ptab_pkg::NUM_LANES-1:0][10:0] c_sum;
   ptab_pkg::rgb8_type c_in, c_ff;
   logic [7:0] alpha3_ff;

   always_comb begin
      pa_rnd  = 17'(pa_ff) + 17'd127;
      add_sel = disabled_look ? pa_rnd[16:8] : addn_ff;
      for (int i = 0; i < ptab_pkg::NUM_LANES; i++) begin
         pt_rnd[i] = 18'(pt_ff[i]) + 18'd127;
         c_sum[i]  = 11'(pt_rnd[i][17:8]) + 11'(add_sel);
         c_in[i]   = (|c_sum[i][10:8]) ? 8'hFF : c_sum[i][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         c_ff      <= c_in;
         alpha3_ff <= alpha2_ff;
      end
   end

   assign chan  = c_ff;
   assign alpha = alpha3_ff;

endmodule

@@ rtl/core/ptab_blend.sv @@
// Blend stages: coverage products, rounded blend and output mode select.
module ptab_blend (
   input  logic                    clock,
   input  ptab_pkg::rgb8_type      chan,
   input  logic [7:0]              alpha,
   input  ptab_pkg::rgb8_type      back,
   input  logic [1:0]              output_mode,
   input  ptab_pkg::stage_en_type  stage_en,
   output ptab_pkg::rsp_type       rsp_data
);

   // Stage 4: foreground and background products
   logic [8:0] inv_alpha;
   logic [ptab_pkg::NUM_LANES-1:0][15:0] pc_in, pc_ff;
   logic [ptab_pkg::NUM_LANES-1:0][16:0] pb_in, pb_ff;
   ptab_pkg::rgb8_type c4_ff;
   logic [7:0] alpha4_ff;

   always_comb begin
      inv_alpha = 9'd256 - {1'b0, alpha};
      for (int i = 0; i < ptab_pkg::NUM_LANES; i++) begin
         pc_in[i] = 16'(chan[i]) * 16'(alpha);
         pb_in[i] = 17'(back[i]) * 17'(inv_alpha);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s4) begin
         pc_ff     <= pc_in;
         pb_ff     <= pb_in;
         c4_ff     <= chan;
         alpha4_ff <= alpha;
      end
   end

   // Stage 5: round, sum, saturate and pick the mode
   logic [ptab_pkg::NUM_LANES-1:0][16:0] pc_rnd;
   logic [ptab_pkg::NUM_LANES-1:0][17:0] pb_rnd;
   logic [ptab_pkg::NUM_LANES-1:0][10:0] b_sum;
   ptab_pkg::rgb8_type blended, rgb_sel;
   logic [7:0] alpha_sel;
   ptab_pkg::rsp_type rsp_in, rsp_ff;

   always_comb begin
      for (int i = 0; i < ptab_pkg::NUM_LANES; i++) begin
         pc_rnd[i]  = 17'(pc_ff[i]) + 17'd127;
         pb_rnd[i]  = 18'(pb_ff[i]) + 18'd127;
         b_sum[i]   = 11'(pc_rnd[i][16:8]) + 11'(pb_rnd[i][17:8]);
         blended[i] = (|b_sum[i][10:8]) ? 8'hFF : b_sum[i][7:0];
      end
      case (output_mode)
         ptab_pkg::MODE_BLEND: begin
            rgb_sel   = blended;
            alpha_sel = 8'hFF;
         end
         ptab_pkg::MODE_ALPHA: begin
            rgb_sel   = c4_ff;
            alpha_sel = alpha4_ff;
         end
         default: begin
            rgb_sel   = c4_ff;
            alpha_sel = 8'hFF;
         end
      endcase
      rsp_in.out_red   = rgb_sel[ptab_pkg::LANE_RED];
      rsp_in.out_green = rgb_sel[ptab_pkg::LANE_GREEN];
      rsp_in.out_blue  = rgb_sel[ptab_pkg::LANE_BLUE];
      rsp_in.out_alpha = alpha_sel;
   end

   always_ff @(posedge clock) begin
      if (stage_en.s5) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ bench/pixel_tint_and_blend_test.sv @@
// Self-checking bench for the pixel tint and blend pipeline, with random flow control.
`timescale 1ns / 100ps

module pixel_tint_and_blend_test;

   // The fourth output-mode code has no name in the package; it must act as opaque
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [1:0] MODE_CYCLE [4] = '{ptab_pkg::MODE_OPAQUE, ptab_pkg::MODE_ALPHA,
                                             ptab_pkg::MODE_BLEND, MODE_UNUSED};

   localparam int unsigned RANDOM_PHASES   = 14;
   localparam int unsigned PHASE_PIXELS    = 100;
   localparam int unsigned DRAIN_CYCLES    = 8;       // five pipeline stages plus margin
   localparam int unsigned CYCLE_LIMIT     = 1000000;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   ptab_pkg::req_type req_data       = '0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   ptab_pkg::rsp_type rsp_data;
   logic              csr_write_en   = 1'b0;
   logic [ptab_pkg::CSR_INDEX_WIDTH-1:0] csr_index      = '0;
   logic [ptab_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   // Local copy of the colouring registers, kept in step with every write we issue
   logic [7:0] tint_colour [ptab_pkg::NUM_LANES] = '{8'd0, 8'd0, 8'd0};
   logic [7:0] back_colour [ptab_pkg::NUM_LANES] = '{8'd0, 8'd0, 8'd0};
   logic       grey_look  = 1'b0;
   logic [1:0] pixel_mode = ptab_pkg::MODE_OPAQUE;

   ptab_pkg::req_type pixel_backlog [$];   // template pixels waiting to be offered
   ptab_pkg::rsp_type rgba_expected [$];   // colourised pixels owed by the block, oldest first
   int unsigned mismatch_total = 0;
   int unsigned cycle_count    = 0;
   int unsigned send_gap       = 0;
   int unsigned take_stall     = 0;
   bit          send_steady    = 1'b0;
   bit          take_steady    = 1'b0;

   pixel_tint_and_blend u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned clamp_byte(input int unsigned value);
      return (value > 255) ? 255 : value;
   endfunction

   // Colourise one template pixel with the current register copy
   function automatic ptab_pkg::rsp_type tint_pixel(input ptab_pkg::req_type px);
      int unsigned scale;
      int unsigned alpha;
      int unsigned boost;
      int unsigned gray;
      int unsigned shade;
      int unsigned tint;
      int unsigned back;
      int unsigned lane_out [ptab_pkg::NUM_LANES];
      ptab_pkg::rsp_type px_out;
      scale = px.scale_value;
      alpha = px.alpha_value;
      boost = px.add_value;
      gray  = 0;
      if (grey_look) begin
         // Desaturate: pull each tint channel a quarter of the way toward its grey
         gray = (11 * int'(tint_colour[ptab_pkg::LANE_RED])
                 + 16 * int'(tint_colour[ptab_pkg::LANE_GREEN])
                 + 5 * int'(tint_colour[ptab_pkg::LANE_BLUE])) >> 5;
         boost = (boost * gray + 127) >> 8;
      end else if (scale != 0) begin
         boost = boost * 5 / 4;
      end
      for (int lane = 0; lane < ptab_pkg::NUM_LANES; lane++) begin
         tint = tint_colour[lane];
         back = back_colour[lane];
         shade = grey_look ? ((3 * tint + gray) >> 2) : (tint + 2);
         lane_out[lane] = clamp_byte(((shade * scale + 127) >> 8) + boost);
         if (pixel_mode == ptab_pkg::MODE_BLEND) begin
            lane_out[lane] = clamp_byte(((lane_out[lane] * alpha + 127) >> 8)
                                        + ((back * (256 - alpha) + 127) >> 8));
         end
      end
      px_out.out_red   = 8'(lane_out[ptab_pkg::LANE_RED]);
      px_out.out_green = 8'(lane_out[ptab_pkg::LANE_GREEN]);
      px_out.out_blue  = 8'(lane_out[ptab_pkg::LANE_BLUE]);
      // Alpha is only passed through in alpha mode; the unused code behaves as opaque
      px_out.out_alpha = (pixel_mode == ptab_pkg::MODE_ALPHA) ? px.alpha_value : 8'd255;
      return px_out;
   endfunction

   // Mostly short gaps, now and then a long one; none at all during a steady stretch
   function automatic int unsigned idle_length(input bit steady);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (steady || pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Uniform byte, biased now and then toward the edges of the range
   function automatic logic [7:0] pick_byte();
      logic [7:0] edges [4];
      edges = '{8'd0, 8'd255, 8'd1, 8'd254};
      if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 3)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] pick_channel(input bit extreme);
      if (extreme) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic check_lane(input string lane, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", lane, want, got);
         mismatch_total++;
      end
   endtask

   // Register write: raise the strobe for one edge, then mirror the value locally
   task automatic write_register(input logic [ptab_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 input logic [ptab_pkg::CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (index)
         ptab_pkg::CSR_TINT_RED:      tint_colour[ptab_pkg::LANE_RED]   = value;
         ptab_pkg::CSR_TINT_GREEN:    tint_colour[ptab_pkg::LANE_GREEN] = value;
         ptab_pkg::CSR_TINT_BLUE:     tint_colour[ptab_pkg::LANE_BLUE]  = value;
         ptab_pkg::CSR_BACK_RED:      back_colour[ptab_pkg::LANE_RED]   = value;
         ptab_pkg::CSR_BACK_GREEN:    back_colour[ptab_pkg::LANE_GREEN] = value;
         ptab_pkg::CSR_BACK_BLUE:     back_colour[ptab_pkg::LANE_BLUE]  = value;
         ptab_pkg::CSR_DISABLED_LOOK: grey_look  = value[0];     // upper bits are dropped
         ptab_pkg::CSR_OUTPUT_MODE:   pixel_mode = value[1:0];
         default: ;
      endcase
   endtask

   task automatic apply_look(input logic [7:0] tr, input logic [7:0] tg, input logic [7:0] tb,
                             input logic [7:0] br, input logic [7:0] bg, input logic [7:0] bb,
                             input logic [7:0] look_byte, input logic [7:0] mode_byte);
      write_register(ptab_pkg::CSR_TINT_RED, tr);
      write_register(ptab_pkg::CSR_TINT_GREEN, tg);
      write_register(ptab_pkg::CSR_TINT_BLUE, tb);
      write_register(ptab_pkg::CSR_BACK_RED, br);
      write_register(ptab_pkg::CSR_BACK_GREEN, bg);
      write_register(ptab_pkg::CSR_BACK_BLUE, bb);
      write_register(ptab_pkg::CSR_DISABLED_LOOK, look_byte);
      write_register(ptab_pkg::CSR_OUTPUT_MODE, mode_byte);
   endtask

   // Hold until every pixel is offered, taken and returned, then let the pipe settle
   task automatic wait_drained();
      do @(posedge clock);
      while (pixel_backlog.size() != 0 || req_valid || rgba_expected.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_edge_pixels();
      ptab_pkg::req_type edge_set [6];
      edge_set = '{'{8'd0,   8'd0,   8'd0},
                   '{8'd255, 8'd255, 8'd255},
                   '{8'd0,   8'd255, 8'd128},
                   '{8'd255, 8'd0,   8'd0},
                   '{8'd1,   8'd4,   8'd255},
                   '{8'd128, 8'd200, 8'd1}};
      foreach (edge_set[i]) pixel_backlog.push_back(edge_set[i]);
   endtask

   // Sender: offer backlog pixels, record what each accepted transaction must produce
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            rgba_expected.push_back(tint_pixel(req_data));
         end
         // Slot is free after this edge: either idle out the gap or load the next pixel
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pixel_backlog.size() != 0) begin
               req_data  <= pixel_backlog.pop_front();
               req_valid <= 1'b1;
               if ($urandom_range(0, 63) == 0) send_steady = !send_steady;
               send_gap = idle_length(send_steady);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall at random, compare each returned transaction with the oldest owed pixel
   always @(posedge clock) begin
      ptab_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         take_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rgba_expected.size() == 0) begin
               $error("pixel returned with none owed: %h", rsp_data);
               mismatch_total++;
            end else begin
               want = rgba_expected.pop_front();
               check_lane("out_red",   want.out_red,   rsp_data.out_red);
               check_lane("out_green", want.out_green, rsp_data.out_green);
               check_lane("out_blue",  want.out_blue,  rsp_data.out_blue);
               check_lane("out_alpha", want.out_alpha, rsp_data.out_alpha);
            end
            if ($urandom_range(0, 63) == 0) take_steady = !take_steady;
         end
         if (take_stall == 0 && $urandom_range(0, 3) == 0) begin
            take_stall = idle_length(take_steady);
         end
         if (take_stall > 0) begin
            take_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run if the pipeline never drains
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pixel_tint_and_blend test failed");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: edge pixels under the reset look (normal, opaque, black tint)
      queue_edge_pixels();
      wait_drained();

      // Full tint, normal look, alpha passed through
      apply_look(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'h00,
                 {6'h00, ptab_pkg::MODE_ALPHA});
      queue_edge_pixels();
      wait_drained();

      // Disabled look set through a wide value, blended onto a white background
      apply_look(8'd255, 8'd128, 8'd0, 8'd255, 8'd255, 8'd255, 8'hFF,
                 {6'h3F, ptab_pkg::MODE_BLEND});
      queue_edge_pixels();
      wait_drained();

      // Unused mode code must look opaque; an even wide value clears the disabled look
      apply_look(8'd40, 8'd200, 8'd90, 8'd10, 8'd20, 8'd30, 8'hFE, {6'h3F, MODE_UNUSED});
      queue_edge_pixels();
      wait_drained();

      // Random phases: walk every mode under both looks, every third phase with extreme colours
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         bit extreme;
         extreme = (phase % 3 == 0);
         apply_look(pick_channel(extreme), pick_channel(extreme), pick_channel(extreme),
                    pick_channel(extreme), pick_channel(extreme), pick_channel(extreme),
                    {7'($urandom_range(0, 127)), 1'((phase / 4) % 2)},
                    {6'($urandom_range(0, 63)), MODE_CYCLE[phase % 4]});
         repeat (PHASE_PIXELS) pixel_backlog.push_back('{pick_byte(), pick_byte(), pick_byte()});
         wait_drained();
      end

      if (mismatch_total == 0) begin
         $display("pixel_tint_and_blend test passed");
      end else begin
         $display("pixel_tint_and_blend test failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/ptab_pkg.sv
rtl/core/ptab_tint.sv
rtl/core/ptab_blend.sv
rtl/core/pixel_tint_and_blend.sv
bench/pixel_tint_and_blend_test.sv
